@@ rtl/core/sha256_block_compression_unit_defines.svh @@
// ----------------------------------------------------------------------------
// sha256 block compression unit assertion macros
// concurrent property wrappers, empty when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef SHA256_BLOCK_COMPRESSION_UNIT_DEFINES_SVH
`define SHA256_BLOCK_COMPRESSION_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 compression unit: assertion failed");
// next-cycle implication
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 compression unit: assertion failed");
`else
`define SBC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/sha256bc_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256bc_pkg
// shared types, constants and sigma functions of the compression unit
// ----------------------------------------------------------------------------
`default_nettype none

package sha256bc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned RoundW  = $clog2(Rounds);
  localparam int unsigned BlkWds  = 16;
  localparam int unsigned CntW    = $clog2(BlkWds);
  localparam int unsigned ChainN  = 8;
  localparam int unsigned IdxW    = $clog2(ChainN);

  localparam logic [CntW-1:0]   LastWordIdx  = CntW'(BlkWds - 1);
  localparam logic [RoundW-1:0] LastRound    = RoundW'(Rounds - 1);
  localparam logic [IdxW-1:0]   LastChainIdx = IdxW'(ChainN - 1);

  // register map, index = byte address / 4
  localparam logic [AddrW-3:0] RegByteSwap = '0;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ChainN-1:0][WordW-1:0] chain_t;
  typedef logic [BlkWds-1:0][WordW-1:0] window_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic load_word;  // shift an accepted message word into the schedule
    logic init_hash;  // reload chaining value with the initial hash
    logic load_vars;  // copy chaining value into working variables
    logic do_round;   // one compression round, schedule steps once
    logic add_back;   // chaining value += working variables
  } ctrl_t;

  localparam word_t ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // element 0 is the first state word
  localparam chain_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sha256bc_sched.sv @@
// ----------------------------------------------------------------------------
// sha256bc_sched
// sixteen-word message schedule window, expands one word per round
// ----------------------------------------------------------------------------
`default_nettype none

module sha256bc_sched
  import sha256bc_pkg::*;
(
  input  wire   clk_i,
  input  ctrl_t ctrl_i,
  input  word_t word_i,
  output word_t w_o
);

  window_t win_q, win_d;
  word_t   w_next;

  // element 0 holds w[t], element 15 the newest word
  assign w_next = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
  assign w_o    = win_q[0];

  always_comb begin
    win_d = win_q;
    if (ctrl_i.load_word) begin
      win_d = {word_i, win_q[BlkWds-1:1]};
    end else if (ctrl_i.do_round) begin
      win_d = {w_next, win_q[BlkWds-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/sha256bc_round.sv @@
// ----------------------------------------------------------------------------
// sha256bc_round
// working variables, shared round datapath and chaining value
// ----------------------------------------------------------------------------
`default_nettype none

module sha256bc_round
  import sha256bc_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  input  ctrl_t  ctrl_i,
  input  word_t  k_i,
  input  word_t  w_i,
  output chain_t chain_o
);

  chain_t cv_q, cv_d;
  chain_t v_q, v_d;
  word_t  t1, t2, ch, maj;

  // v_q[0] is a, v_q[7] is h
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + k_i + w_i;
  assign t2  = big_sigma0(v_q[0]) + maj;

  always_comb begin
    v_d = v_q;
    if (ctrl_i.load_vars) begin
      v_d = cv_q;
    end else if (ctrl_i.do_round) begin
      v_d = {v_q[6], v_q[5], v_q[4], v_q[3] + t1, v_q[2], v_q[1], v_q[0], t1 + t2};
    end
  end

  always_comb begin
    cv_d = cv_q;
    if (ctrl_i.init_hash) begin
      cv_d = INIT_HASH;
    end else if (ctrl_i.add_back) begin
      for (int i = 0; i < ChainN; i++) begin
        cv_d[i] = cv_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= INIT_HASH;
    end else begin
      cv_q <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign chain_o = cv_q;

endmodule

`default_nettype wire

@@ rtl/core/sha256_block_compression_unit.sv @@
// sha256 block compression unit
// sequence: words 0..14 fill the schedule; word 15 starts 64 rounds (one per cycle),
//   then the add-back into the chaining value, then the digest words are emitted
// input: no new word is taken until the digest of the block has been emitted, a limit set
//   by the single round datapath that is reused for all 64 rounds
// reset: chaining value = initial hash, word count 0, byte swap off, output empty
// ----------------------------------------------------------------------------
// sha256_block_compression_unit
// sha-256 compression engine with apb control, one message word per transaction
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_block_compression_unit_defines.svh"

module sha256_block_compression_unit
  import sha256bc_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  // apb configuration port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [AddrW-1:0]  paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // message word channel
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [WordW-1:0]  message_word_i,
  input  wire               start_new_i,
  // digest channel
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [WordW-1:0]  digest_word_o,
  output logic [IdxW-1:0]   word_index_o,
  output logic              last_o
);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic byte_swap_q, byte_swap_d;
  logic cfg_wr;

  // only the register index bits decode, byte offset bits are ignored
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    byte_swap_d = byte_swap_q;
    if (cfg_wr && (paddr[AddrW-1:2] == RegByteSwap)) begin
      byte_swap_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[AddrW-1:2] == RegByteSwap) begin
      prdata = {31'b0, byte_swap_q};
    end
  end

  // --------------------------------------------------------------------------
  // sequencer state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;     // words of the current block received
  logic [RoundW-1:0] rnd_q, rnd_d;     // round number
  logic [IdxW-1:0]   emit_q, emit_d;   // next chaining word to emit

  logic   in_acc;
  logic   final_word;
  logic   emit_go;
  word_t  word_in;
  ctrl_t  ctrl;
  word_t  w_cur;
  chain_t chain;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  // a start flag makes the word word 0 of a new block, so it never closes one
  assign final_word = !start_new_i && (cnt_q == LastWordIdx);

  assign word_in = byte_swap_q
                 ? {message_word_i[7:0], message_word_i[15:8],
                    message_word_i[23:16], message_word_i[31:24]}
                 : message_word_i;

  // the output register must be free before the next chaining word moves in
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);

  always_comb begin
    ctrl.load_word = in_acc;
    ctrl.init_hash = in_acc & start_new_i;
    ctrl.load_vars = in_acc & final_word;
    ctrl.do_round  = (state_q == ST_ROUND);
    ctrl.add_back  = (state_q == ST_FINAL);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    emit_d  = emit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (start_new_i) begin
            cnt_d = CntW'(1);
          end else if (final_word) begin
            cnt_d   = '0;
            rnd_d   = '0;
            state_d = ST_ROUND;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      ST_ROUND: begin
        rnd_d = rnd_q + RoundW'(1);
        if (rnd_q == LastRound) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        emit_d  = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          emit_d = emit_q + IdxW'(1);
          if (emit_q == LastChainIdx) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rnd_q       <= '0;
      emit_q      <= '0;
      byte_swap_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      emit_q      <= emit_d;
      byte_swap_q <= byte_swap_d;
    end
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  sha256bc_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .word_i (word_in),
    .w_o    (w_cur)
  );

  sha256bc_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .k_i     (ROUND_K[rnd_q]),
    .w_i     (w_cur),
    .chain_o (chain)
  );

  // --------------------------------------------------------------------------
  // output register, holds a digest word until its transaction completes
  // --------------------------------------------------------------------------
  logic out_valid_q, out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      digest_word_o <= chain[emit_q];
      word_index_o  <= emit_q;
      last_o        <= (emit_q == LastChainIdx);
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the closing word of a block starts the round loop
  `SBC_ASSERT_NEXT(a_final_word_starts, clk_i, rst_ni, in_acc && final_word, state_q == ST_ROUND && rnd_q == '0)
  // the round loop ends after the last round
  `SBC_ASSERT_NEXT(a_rounds_end, clk_i, rst_ni, state_q == ST_ROUND && rnd_q == LastRound, state_q == ST_FINAL)
  // emission always begins at the first chaining word
  `SBC_ASSERT_NEXT(a_emit_from_zero, clk_i, rst_ni, state_q == ST_FINAL, state_q == ST_EMIT && emit_q == '0)
  // no message word is taken while a block is being compressed or emitted
  `SBC_ASSERT_SAME(a_no_input_busy, clk_i, rst_ni, state_q != ST_IDLE, !in_acc)

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: sha256 block compression unit testbench
// drives message words through the valid/ready input channel, predicts every
// chaining value with a behavioral sha-256 compression model and checks each
// digest transaction in order; byte swap is reprogrammed over apb between
// phases with different idle and stall patterns
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import sha256bc_pkg::*;
();

  // register addresses, byte address = 4 * register index
  localparam logic [AddrW-3:0] RegSpare  = 1'b1;  // no register behind this index
  localparam logic [AddrW-1:0] SwapAddr  = {RegByteSwap, 2'b00};
  localparam logic [AddrW-1:0] SpareAddr = {RegSpare, 2'b00};

  localparam int unsigned DrainCycles = 100;  // a bit more than one block time
  localparam int unsigned HoldCycles  = 400;  // long sink hold-off for back pressure

  // sha-256 round constants
  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // standard initial hash value, element 0 is the first state word
  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // well known digest of the padded one-block message "abc"
  localparam word_t AbcDigest [8] = '{
    32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
    32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
  };

  typedef struct packed {
    word_t word;
    logic  start;
    logic  known;  // block ends here and its digest is the abc vector
  } stim_row_t;

  typedef struct packed {
    word_t           digest;
    logic [IdxW-1:0] idx;
    logic            last;
  } digest_rec_t;

  // directed words: abc block right after reset without a start flag (chaining
  // value must come from reset), then extremes and a restart inside a block
  localparam int unsigned DirN = 25;
  localparam stim_row_t DirRows [DirN] = '{
    '{32'h61626380, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000018, 1'b0, 1'b1},
    // new hash with extreme words, then a start flag in the middle of it
    '{32'hffffffff, 1'b1, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0}, '{32'h80000000, 1'b0, 1'b0},
    '{32'h00000001, 1'b1, 1'b0}, '{32'hffffffff, 1'b0, 1'b0},
    '{32'h7fffffff, 1'b0, 1'b0}, '{32'hfffffffe, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}
  };

  // dut ports, every input known from time zero
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [AddrW-1:0]  paddr          = '0;
  logic [31:0]       pwdata         = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [WordW-1:0]  message_word_i = '0;
  logic              start_new_i    = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [WordW-1:0]  digest_word_o;
  logic [IdxW-1:0]   word_index_o;
  logic              last_o;

  // predictor state: chaining value, block buffer, word count, byte swap
  word_t       chain_q [8];
  word_t       blk_q   [16];
  logic [3:0]  cnt_q;
  logic        swap_q;

  digest_rec_t digest_q [$];   // digest words still owed by the unit
  digest_rec_t seen_rec;
  int unsigned fail_cnt       = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_armed     = 1'b0;  // set once by the sequencer
  logic        hold_used      = 1'b0;  // owned by the sink process
  int unsigned hold_left      = 0;

  sha256_block_compression_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .start_new_i    (start_new_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // behavioral sha-256 compression
  // ---------------------------------------------------------------------------
  function automatic word_t ror32(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t sched [64];
    word_t v [8];
    word_t x, y, t1, t2;
    for (int i = 0; i < 16; i++) sched[i] = blk_q[i];
    // message schedule expansion
    for (int i = 16; i < 64; i++) begin
      x = sched[i-15];
      y = sched[i-2];
      sched[i] = (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10)) + sched[i-7]
               + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + sched[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + sched[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] = chain_q[i] + v[i];
  endfunction

  // takes one accepted word, returns 1 when it completed a block
  function automatic bit absorb_word(input word_t w, input logic s);
    word_t v;
    v = swap_q ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
    if (s) begin
      // start flag drops any partial block and reloads the initial hash
      chain_q = InitHash;
      cnt_q   = '0;
    end
    blk_q[cnt_q] = v;
    if (cnt_q != 4'hf) begin
      cnt_q = cnt_q + 4'h1;
      return 1'b0;
    end
    cnt_q = '0;
    compress_block();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // message word sender, called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input word_t w, input logic s, input logic known);
    digest_rec_t rec;
    // random sender gaps
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    message_word_i = w;
    start_new_i    = s;
    // hold the transaction until the unit takes it
    do @(posedge clk_i); while (!in_ready_o);
    if (absorb_word(w, s)) begin
      for (int k = 0; k < 8; k++) begin
        rec.digest = known ? AbcDigest[k] : chain_q[k];
        rec.idx    = IdxW'(k);
        rec.last   = (k == 7);
        digest_q.push_back(rec);
      end
    end
    @(negedge clk_i);
  endtask

  // random word with extra weight on all-zero and all-one
  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly whole blocks with a start flag, some chained blocks without one,
  // some blocks cut short so the next start flag restarts them
  task automatic feed_blocks(input int unsigned n_words);
    int unsigned sent;
    int unsigned mode;
    int unsigned len;
    sent = 0;
    while (sent < n_words) begin
      mode = $urandom_range(0, 9);
      len  = (mode >= 8) ? $urandom_range(1, 15) : 16;
      for (int unsigned i = 0; i < len; i++) begin
        send_word(pick_word(), (i == 0) && (mode <= 5 || mode >= 8), 1'b0);
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // apb access: write, then read back the byte swap register
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    // setup cycle
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    // access cycle
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == SwapAddr) swap_q = data[0];  // bits above bit 0 are ignored
    @(negedge clk_i);
    // readback
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = SwapAddr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== swap_q) begin
      $display("%0t: byte swap readback expected %0b actual %0b", $time, swap_q, prdata[0]);
      fail_cnt++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // wait until every digest word came out, then let a partial block settle
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // digest sink: random stalls plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_armed && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // digest checker, compares each transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b",
                 $time, digest_word_o, word_index_o, last_o);
        fail_cnt++;
      end else begin
        seen_rec = digest_q.pop_front();
        if (digest_word_o !== seen_rec.digest) begin
          $display("%0t: digest word expected %h actual %h",
                   $time, seen_rec.digest, digest_word_o);
          fail_cnt++;
        end
        if (word_index_o !== seen_rec.idx) begin
          $display("%0t: word index expected %0d actual %0d",
                   $time, seen_rec.idx, word_index_o);
          fail_cnt++;
        end
        if (last_o !== seen_rec.last) begin
          $display("%0t: last expected %0b actual %0b", $time, seen_rec.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  initial begin
    // predictor reset state
    chain_q = InitHash;
    for (int i = 0; i < 16; i++) blk_q[i] = '0;
    cnt_q  = '0;
    swap_q = 1'b0;

    // reset held, then released on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table with reset byte swap setting
    for (int unsigned r = 0; r < DirN; r++) begin
      send_word(DirRows[r].word, DirRows[r].start, DirRows[r].known);
    end

    // phase 1: swap on, no idling
    wait_drained();
    cfg_write(SwapAddr, {31'($urandom), 1'b1});
    feed_blocks(40);

    // phase 2: swap off, sender idle 60 percent; a write to the unmapped
    // register index must leave byte swap alone
    wait_drained();
    cfg_write(SwapAddr, {31'($urandom), 1'b0});
    cfg_write(SpareAddr, 32'hffffffff);
    src_idle_pct   = 60;
    sink_stall_pct = 0;
    feed_blocks(40);

    // phase 3: swap on, sink stalls 60 percent
    wait_drained();
    cfg_write(SwapAddr, 32'hffffffff);
    src_idle_pct   = 0;
    sink_stall_pct = 60;
    feed_blocks(40);

    // phase 4: random swap, both sides idle 21 percent
    wait_drained();
    cfg_write(SwapAddr, $urandom);
    src_idle_pct   = 21;
    sink_stall_pct = 21;
    feed_blocks(40);

    // phase 5: swap off, sink holds off for a long stretch while words keep
    // coming, so pending digests back up into the input channel
    wait_drained();
    cfg_write(SwapAddr, 32'h00000000);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_armed     = 1'b1;
    feed_blocks(44);

    // drain and report
    wait_drained();
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard limit on run length
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ sha256_block_compression_unit.f @@
+incdir+rtl/core
rtl/core/sha256bc_pkg.sv
rtl/core/sha256bc_sched.sv
rtl/core/sha256bc_round.sv
rtl/core/sha256_block_compression_unit.sv
test/tb_top.sv
